[rtl/clcd_pkg.sv]
// Shared types, request codes and the microcode program of the character LCD
// 4-bit nibble sequencer. No dependencies; used by the top level, both checkers and the testbench.
`default_nettype none
package clcd_pkg;

   // Request codes
   localparam logic [1:0] REQ_CHAR  = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_POS   = 2'd2;
   localparam logic [1:0] REQ_INIT  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_ROW2_OFFSET = 2'd0;
   localparam logic [1:0] CSR_ROW3_OFFSET = 2'd1;
   localparam logic [1:0] CSR_CHAR_GAP    = 2'd2;

   // Reset values of the configuration registers
   localparam logic [6:0] ROW2_OFFSET_RST = 7'd20;
   localparam logic [6:0] ROW3_OFFSET_RST = 7'd84;
   localparam logic [9:0] CHAR_GAP_RST    = 10'd10;

   // Display address constants
   localparam logic [7:0] ROW1_OFFSET = 8'h40;
   localparam logic [7:0] SET_DDRAM   = 8'h80;

   // Wait times in microseconds
   localparam logic [17:0] POWERUP_WAIT_US = 18'd150000;
   localparam logic [17:0] WAKE_WAIT_US    = 18'd4500;
   localparam logic [17:0] CLEAR_WAIT_US   = 18'd2000;
   localparam logic [17:0] CMD_WAIT_US     = 18'd1000;
   localparam logic [17:0] FINAL_WAIT_US   = 18'd202000;

   // Program counter and entry points of each routine
   localparam int unsigned PC_W = 5;
   localparam logic [PC_W-1:0] ENTRY_CHAR  = 5'd0;
   localparam logic [PC_W-1:0] ENTRY_CLEAR = 5'd2;
   localparam logic [PC_W-1:0] ENTRY_POS   = 5'd4;
   localparam logic [PC_W-1:0] ENTRY_INIT  = 5'd6;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [7:0] column;
      logic [7:0] row;
   } req_data_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic [17:0] wait_before_us;
      logic [17:0] wait_after_us;
      logic        last;
   } rsp_data_type;

   // Where the nibble of a step comes from
   typedef enum logic [1:0] {
      NIB_CONST = 2'd0,
      NIB_HIGH  = 2'd1,
      NIB_LOW   = 2'd2
   } nib_sel_type;

   // Wait that follows a strobe
   typedef enum logic [2:0] {
      WAIT_NONE  = 3'd0,
      WAIT_GAP   = 3'd1,
      WAIT_CMD   = 3'd2,
      WAIT_CLEAR = 3'd3,
      WAIT_WAKE  = 3'd4,
      WAIT_FINAL = 3'd5
   } wait_sel_type;

   // One control word of the program
   typedef struct packed {
      logic         reg_select;
      nib_sel_type  nib_sel;
      logic [3:0]   nib_const;
      logic         powerup_wait;
      wait_sel_type wait_sel;
      logic         last;
   } ctrl_word_type;

   function automatic ctrl_word_type make_word(input logic rs, input nib_sel_type sel,
                                               input logic [3:0] nib, input logic pwr,
                                               input wait_sel_type ws, input logic last);
      ctrl_word_type w;
      w.reg_select   = rs;
      w.nib_sel      = sel;
      w.nib_const    = nib;
      w.powerup_wait = pwr;
      w.wait_sel     = ws;
      w.last         = last;
      return w;
   endfunction

   // Program store: character, clear, set position, then power-on init
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         5'd0:  w = make_word(1'b1, NIB_HIGH,  4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd1:  w = make_word(1'b1, NIB_LOW,   4'h0, 1'b0, WAIT_GAP,   1'b1);
         5'd2:  w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd3:  w = make_word(1'b0, NIB_CONST, 4'h1, 1'b0, WAIT_CLEAR, 1'b1);
         5'd4:  w = make_word(1'b0, NIB_HIGH,  4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd5:  w = make_word(1'b0, NIB_LOW,   4'h0, 1'b0, WAIT_NONE,  1'b1);
         5'd6:  w = make_word(1'b0, NIB_CONST, 4'h3, 1'b1, WAIT_WAKE,  1'b0);
         5'd7:  w = make_word(1'b0, NIB_CONST, 4'h3, 1'b0, WAIT_WAKE,  1'b0);
         5'd8:  w = make_word(1'b0, NIB_CONST, 4'h3, 1'b0, WAIT_WAKE,  1'b0);
         5'd9:  w = make_word(1'b0, NIB_CONST, 4'h2, 1'b0, WAIT_NONE,  1'b0);
         5'd10: w = make_word(1'b0, NIB_CONST, 4'h2, 1'b0, WAIT_NONE,  1'b0);
         5'd11: w = make_word(1'b0, NIB_CONST, 4'h8, 1'b0, WAIT_NONE,  1'b0);
         5'd12: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd13: w = make_word(1'b0, NIB_CONST, 4'h8, 1'b0, WAIT_CMD,   1'b0);
         5'd14: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd15: w = make_word(1'b0, NIB_CONST, 4'h1, 1'b0, WAIT_CLEAR, 1'b0);
         5'd16: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd17: w = make_word(1'b0, NIB_CONST, 4'h6, 1'b0, WAIT_CMD,   1'b0);
         5'd18: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd19: w = make_word(1'b0, NIB_CONST, 4'hC, 1'b0, WAIT_NONE,  1'b0);
         5'd20: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE,  1'b0);
         5'd21: w = make_word(1'b0, NIB_CONST, 4'h2, 1'b0, WAIT_NONE,  1'b0);
         5'd22: w = make_word(1'b0, NIB_CONST, 4'h8, 1'b0, WAIT_NONE,  1'b0);
         5'd23: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_FINAL, 1'b1);
         default: w = make_word(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_NONE, 1'b1);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[rtl/char_lcd_4bit_nibble_sequencer.sv]
// Top level of the character LCD 4-bit nibble sequencer: request intake,
// microcode step counter, nibble datapath and output register. Uses clcd_pkg.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data) takes one request: write
//    character, clear, set position or initialise.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data) gives one nibble strobe per
//    transfer: RS, D7..D4, waits before/after, and last on the final one.
//  - csr port writes row2_offset, row3_offset and char_gap_us; the user must
//    write them only while idle, which the block itself does not enforce.
// Timing: a request is first captured in the step counter and data register,
// and its first nibble then enters the output register. The microcode counter
// issues one step a cycle while rsp is not stalled; the next request is taken
// in the cycle of the final step. A zero character code gives no nibbles.
// A stall on rsp holds the output register and freezes the step counter.
// Reset (synchronous) empties the output register, stops the program,
// restores the register defaults and clears the stored position command.
`default_nettype none
module char_lcd_4bit_nibble_sequencer import clcd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_data_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_data_type rsp_data,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [9:0]   csr_wdata
);

   logic [6:0]      row2_offset_ff, row3_offset_ff;
   logic [9:0]      char_gap_ff;
   logic [7:0]      pos_cmd_ff, pos_cmd_in;
   logic [7:0]      data_ff, data_in;
   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_data_type    rsp_data_ff, rsp_data_in;

   ctrl_word_type   word;
   logic            advance;
   logic            accept;
   logic            no_output;
   logic [7:0]      row_off;
   logic [7:0]      addr_sum;

   // Current control word
   assign word    = ucode(pc_ff);
   assign advance = busy_ff && (!rsp_valid_ff || !rsp_stall);

   // Take the next request alongside the final step of the current one
   assign req_stall = busy_ff && !(advance && word.last);
   assign accept    = req_valid && !req_stall;
   assign no_output = (req_data.req_type == REQ_CHAR) && (req_data.char_code == 8'h00);

   // Set position address
   always_comb begin
      case (req_data.row[1:0])
         2'd0:    row_off = 8'h00;
         2'd1:    row_off = ROW1_OFFSET;
         2'd2:    row_off = {1'b0, row2_offset_ff};
         default: row_off = {1'b0, row3_offset_ff};
      endcase
      addr_sum = row_off + req_data.column;
   end

   always_comb begin
      pos_cmd_in = pos_cmd_ff;
      if (accept && (req_data.req_type == REQ_POS) && (req_data.row[7:2] == 6'd0)) begin
         pos_cmd_in = addr_sum | SET_DDRAM;
      end
      data_in = data_ff;
      if (accept) begin
         data_in = (req_data.req_type == REQ_POS) ? pos_cmd_in : req_data.char_code;
      end
   end

   // Step counter and program entry
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (advance) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
      if (accept && !no_output) begin
         busy_in = 1'b1;
         case (req_data.req_type)
            REQ_CHAR:  pc_in = ENTRY_CHAR;
            REQ_CLEAR: pc_in = ENTRY_CLEAR;
            REQ_POS:   pc_in = ENTRY_POS;
            default:   pc_in = ENTRY_INIT;
         endcase
      end
   end

   // Nibble datapath into the output register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.reg_select = word.reg_select;
         rsp_data_in.last       = word.last;
         case (word.nib_sel)
            NIB_HIGH: rsp_data_in.nibble = data_ff[7:4];
            NIB_LOW:  rsp_data_in.nibble = data_ff[3:0];
            default:  rsp_data_in.nibble = word.nib_const;
         endcase
         rsp_data_in.wait_before_us = word.powerup_wait ? POWERUP_WAIT_US : 18'd0;
         case (word.wait_sel)
            WAIT_GAP:   rsp_data_in.wait_after_us = {8'd0, char_gap_ff};
            WAIT_CMD:   rsp_data_in.wait_after_us = CMD_WAIT_US;
            WAIT_CLEAR: rsp_data_in.wait_after_us = CLEAR_WAIT_US;
            WAIT_WAKE:  rsp_data_in.wait_after_us = WAKE_WAIT_US;
            WAIT_FINAL: rsp_data_in.wait_after_us = FINAL_WAIT_US;
            default:    rsp_data_in.wait_after_us = 18'd0;
         endcase
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         pc_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         pos_cmd_ff     <= 8'h00;
         row2_offset_ff <= ROW2_OFFSET_RST;
         row3_offset_ff <= ROW3_OFFSET_RST;
         char_gap_ff    <= CHAR_GAP_RST;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_cmd_ff   <= pos_cmd_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROW2_OFFSET: row2_offset_ff <= csr_wdata[6:0];
               CSR_ROW3_OFFSET: row3_offset_ff <= csr_wdata[6:0];
               CSR_CHAR_GAP:    char_gap_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/clcd_checker.sv]
// Port-level checker for the character LCD nibble sequencer, with the bind
// that attaches it to the top level. Uses clcd_pkg.
`default_nettype none
module clcd_checker import clcd_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_data_type rsp_data
);

   // A stalled strobe on rsp holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // Output empties at reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Only the first power-on nibble carries a wait before it
   a_powerup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.wait_before_us != 18'd0) |->
         (rsp_data.nibble == 4'h3) && !rsp_data.reg_select && !rsp_data.last)
      else $error("unexpected wait before strobe");

   // Character data high nibble carries no waits and is never last
   a_char_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_select && !rsp_data.last |->
         (rsp_data.wait_after_us == 18'd0) && (rsp_data.wait_before_us == 18'd0))
      else $error("character high nibble with wait");

   // A new request is not taken while a nibble waits and the sequencer holds
   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall && !rsp_data.last) && rsp_valid && rsp_stall
         && !rsp_data.last |-> req_stall)
      else $error("request taken mid-sequence");

endmodule

bind char_lcd_4bit_nibble_sequencer clcd_checker u_clcd_checker (.*);
`default_nettype wire

[verif/clcd_strobe_checker.sv]
// Scoreboard for the character LCD nibble sequencer: watches the request, strobe
// and register ports, predicts every nibble strobe and compares. Uses clcd_pkg.
`default_nettype none
module clcd_strobe_checker import clcd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_data_type req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_data_type rsp_data,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [9:0]   csr_wdata,
   output int                mismatch_count,
   output int                strobes_pending
);

   // Display command bytes and waits, in microseconds
   localparam logic [7:0]  CMD_CLEAR    = 8'h01;
   localparam logic [7:0]  CMD_ADDR_BIT = 8'h80;
   localparam logic [17:0] US_POWERUP   = 18'd150000;
   localparam logic [17:0] US_WAKE      = 18'd4500;
   localparam logic [17:0] US_CLEAR     = 18'd2000;
   localparam logic [17:0] US_CMD       = 18'd1000;
   localparam logic [17:0] US_FINAL     = 18'd202000;

   logic [6:0]   row2_off;
   logic [6:0]   row3_off;
   logic [9:0]   gap_us;
   logic [7:0]   pos_cmd;
   rsp_data_type strobe_q[$];
   int           fail_total;

   function automatic void add_strobe(input logic rs, input logic [3:0] nib,
                                      input logic [17:0] wait_pre,
                                      input logic [17:0] wait_post, input logic fin);
      rsp_data_type s;
      s.reg_select     = rs;
      s.nibble         = nib;
      s.wait_before_us = wait_pre;
      s.wait_after_us  = wait_post;
      s.last           = fin;
      strobe_q.push_back(s);
   endfunction

   // A byte goes out high nibble first; only the low one carries the wait
   function automatic void add_byte(input logic rs, input logic [7:0] val,
                                    input logic [17:0] wait_post, input logic fin);
      add_strobe(rs, val[7:4], '0, '0, 1'b0);
      add_strobe(rs, val[3:0], '0, wait_post, fin);
   endfunction

   function automatic void predict_strobes(input req_data_type r);
      logic [7:0] row_base;
      case (r.req_type)
         REQ_CHAR: begin
            // a zero code is swallowed
            if (r.char_code != 8'd0)
               add_byte(1'b1, r.char_code, {8'd0, gap_us}, 1'b1);
         end
         REQ_CLEAR: begin
            add_byte(1'b0, CMD_CLEAR, US_CLEAR, 1'b1);
         end
         REQ_POS: begin
            // rows past the fourth resend the previous address command
            if (r.row <= 8'd3) begin
               case (r.row[1:0])
                  2'd0:    row_base = 8'h00;
                  2'd1:    row_base = 8'h40;
                  2'd2:    row_base = {1'b0, row2_off};
                  default: row_base = {1'b0, row3_off};
               endcase
               pos_cmd = (row_base + r.column) | CMD_ADDR_BIT;
            end
            add_byte(1'b0, pos_cmd, '0, 1'b1);
         end
         default: begin
            // power-on wake-up: three 0x3 nibbles, then switch to 4-bit mode and send the setup bytes
            add_strobe(1'b0, 4'h3, US_POWERUP, US_WAKE, 1'b0);
            add_strobe(1'b0, 4'h3, '0, US_WAKE, 1'b0);
            add_strobe(1'b0, 4'h3, '0, US_WAKE, 1'b0);
            add_strobe(1'b0, 4'h2, '0, '0, 1'b0);
            add_byte(1'b0, 8'h28, '0, 1'b0);
            add_byte(1'b0, 8'h08, US_CMD, 1'b0);
            add_byte(1'b0, 8'h01, US_CLEAR, 1'b0);
            add_byte(1'b0, 8'h06, US_CMD, 1'b0);
            add_byte(1'b0, 8'h0C, '0, 1'b0);
            add_byte(1'b0, 8'h02, '0, 1'b0);
            add_byte(1'b0, 8'h80, US_FINAL, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_data_type want;
      logic         bad;
      if (reset) begin
         row2_off   = 7'd20;
         row3_off   = 7'd84;
         gap_us     = 10'd10;
         pos_cmd    = 8'h00;
         fail_total = 0;
         strobe_q.delete();
      end else begin
         // strobes are compared first: none can belong to a request taken now
         if (rsp_valid && !rsp_stall) begin
            if (strobe_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("checker: unexpected strobe rs=%0d nib=%h pre=%0d post=%0d last=%0d",
                           rsp_data.reg_select, rsp_data.nibble, rsp_data.wait_before_us,
                           rsp_data.wait_after_us, rsp_data.last);
            end else begin
               want = strobe_q.pop_front();
               bad  = (rsp_data.reg_select != want.reg_select) ||
                      (rsp_data.nibble != want.nibble) ||
                      (rsp_data.wait_before_us != want.wait_before_us) ||
                      (rsp_data.wait_after_us != want.wait_after_us) ||
                      (rsp_data.last != want.last);
               if (bad) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"checker: strobe mismatch exp rs=%0d nib=%h pre=%0d post=%0d",
                               " last=%0d, got rs=%0d nib=%h pre=%0d post=%0d last=%0d"},
                              want.reg_select, want.nibble, want.wait_before_us,
                              want.wait_after_us, want.last, rsp_data.reg_select,
                              rsp_data.nibble, rsp_data.wait_before_us,
                              rsp_data.wait_after_us, rsp_data.last);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_strobes(req_data);
         // register writes, masked to width; a spare index is ignored
         if (csr_we) begin
            case (csr_index)
               CSR_ROW2_OFFSET: row2_off = csr_wdata[6:0];
               CSR_ROW3_OFFSET: row3_off = csr_wdata[6:0];
               CSR_CHAR_GAP:    gap_us   = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatch_count  <= fail_total;
      strobes_pending <= strobe_q.size();
   end

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench top for the character LCD nibble sequencer: clock, reset, request
// and register stimulus, receiver stalls and verdict. Uses clcd_pkg and clcd_strobe_checker.
`default_nettype none
module tb import clcd_pkg::*; ();

   localparam int         CYCLE_LIMIT = 400000;
   localparam int         HOLD_CYCLES = 200;
   localparam logic [1:0] CSR_SPARE   = 2'd3;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [9:0]   csr_wdata;
   int           mismatch_count;
   int           strobes_pending;
   int           cycle_count = 0;
   int           hold_asked = 0;
   int           hold_done = 0;

   always #2 clock = ~clock;

   char_lcd_4bit_nibble_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   clcd_strobe_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .strobes_pending (strobes_pending)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Receiver: segments of differing stall density, plus the long hold-off
   initial begin
      int mode;
      int seg;
      rsp_stall = 1'b0;
      forever begin
         if (hold_asked != hold_done) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_done++;
         end
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(10, 60);
         repeat (seg) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   function automatic req_data_type make_req(input logic [1:0] kind, input logic [7:0] code,
                                             input logic [7:0] col, input logic [7:0] line);
      req_data_type r;
      r.req_type  = kind;
      r.char_code = code;
      r.column    = col;
      r.row       = line;
      return r;
   endfunction

   // Mostly characters and cursor moves, a few clears and the odd initialise
   function automatic req_data_type random_request();
      req_data_type r;
      int           pick;
      r    = make_req(REQ_CHAR, 8'($urandom), 8'($urandom), 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.req_type = REQ_CHAR;
         if ($urandom_range(0, 11) == 0)
            r.char_code = 8'd0;
      end else if (pick < 60) begin
         r.req_type = REQ_CLEAR;
      end else if (pick < 92) begin
         r.req_type = REQ_POS;
         if ($urandom_range(0, 6) != 0)
            r.row = 8'($urandom_range(0, 3));
      end else begin
         r.req_type = REQ_INIT;
      end
      return r;
   endfunction

   // Offer one request and hold it until taken
   task automatic send_req(input req_data_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_for(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      req_data  <= 26'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   // Block is idle once every strobe is out and any zero-code request has passed
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (strobes_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [9:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input int phase);
      case (phase)
         0: begin
            csr_write(CSR_ROW2_OFFSET, 10'd0);
            csr_write(CSR_ROW3_OFFSET, 10'd127);
            csr_write(CSR_CHAR_GAP, 10'd0);
         end
         1: begin
            csr_write(CSR_ROW2_OFFSET, 10'd127);
            csr_write(CSR_ROW3_OFFSET, 10'd0);
            csr_write(CSR_CHAR_GAP, 10'd1000);
            csr_write(CSR_SPARE, 10'h3FF);
         end
         2: begin
            // upper bits beyond the offset width are dropped
            csr_write(CSR_ROW2_OFFSET, 10'h3FF);
            csr_write(CSR_ROW3_OFFSET, 10'h380);
            csr_write(CSR_CHAR_GAP, 10'h3FF);
         end
         default: begin
            csr_write(CSR_ROW2_OFFSET, 10'($urandom_range(0, 1023)));
            csr_write(CSR_ROW3_OFFSET, 10'($urandom_range(0, 1023)));
            csr_write(CSR_CHAR_GAP, 10'($urandom_range(0, 1023)));
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_bursts(input int total);
      int sent;
      int burst;
      sent = 0;
      while (sent < total) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            send_req(random_request());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_for($urandom_range(1, 8));
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_ROW2_OFFSET;
      csr_wdata = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: row past the fourth before any move resends the reset command
      send_req(make_req(REQ_POS, 8'h00, 8'h00, 8'd5));
      send_req(make_req(REQ_CHAR, 8'h00, 8'hFF, 8'hFF));
      send_req(make_req(REQ_CHAR, 8'hFF, 8'h00, 8'h00));
      send_req(make_req(REQ_CHAR, 8'h5A, 8'h00, 8'h00));
      idle_for(3);
      send_req(make_req(REQ_CHAR, 8'hA5, 8'h00, 8'h00));
      send_req(make_req(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF));
      send_req(make_req(REQ_POS, 8'h00, 8'h00, 8'd0));
      send_req(make_req(REQ_POS, 8'h00, 8'hFF, 8'd1));
      send_req(make_req(REQ_POS, 8'h00, 8'h00, 8'd2));
      send_req(make_req(REQ_POS, 8'hFF, 8'hFF, 8'd3));
      send_req(make_req(REQ_POS, 8'h00, 8'h07, 8'd4));
      send_req(make_req(REQ_POS, 8'h00, 8'h00, 8'hFF));
      send_req(make_req(REQ_INIT, 8'hFF, 8'hFF, 8'hFF));
      send_req(make_req(REQ_CHAR, 8'h41, 8'h00, 8'h00));
      send_req(make_req(REQ_INIT, 8'h00, 8'h00, 8'h00));
      send_req(make_req(REQ_POS, 8'h00, 8'hAC, 8'd2));
      send_req(make_req(REQ_CHAR, 8'h00, 8'h00, 8'h00));
      send_req(make_req(REQ_CLEAR, 8'h00, 8'h00, 8'h00));
      wait_idle();

      // random phases under different register settings
      for (int phase = 0; phase < 4; phase++) begin
         configure(phase);
         if (phase == 1)
            hold_asked++;
         random_bursts(80);
         wait_idle();
      end

      repeat (24) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
